FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define LPPP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lppp assertion failed");

// Clocked assertion that also holds during reset.
`define LPPP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lppp assertion failed");

`endif

FILE: rtl/lppp_pkg.sv
`default_nettype none

package lppp_pkg;

  // Flag bytes that open a packet
  localparam logic [7:0] FLAG_FIRST  = 8'hFF;
  localparam logic [7:0] FLAG_SECOND = 8'hEE;

  // Point queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [15:0] azimuth;
    logic [5:0]  channel_id;
    logic [15:0] distance;
    logic [7:0]  reflectivity;
    logic [3:0]  block_index;
    logic        last_of_packet;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/lppp_if.sv
`default_nettype none

// Byte stream channel
interface lppp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Point channel
interface lppp_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] azimuth;
  logic [5:0]  channel_id;
  logic [15:0] distance;
  logic [7:0]  reflectivity;
  logic [3:0]  block_index;
  logic        last_of_packet;

  modport source (output valid, output azimuth, output channel_id, output distance,
                  output reflectivity, output block_index, output last_of_packet,
                  input ready);
  modport sink   (input valid, input azimuth, input channel_id, input distance,
                  input reflectivity, input block_index, input last_of_packet,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lppp_front.sv
`default_nettype none

// Byte parser: finds the packet flag, walks blocks and records, emits points
module lppp_front
  import lppp_pkg::*;
#(
  parameter int BLOCKS_PER_PACKET  = 12,
  parameter int CHANNELS_PER_BLOCK = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  lppp_byte_if.sink          in_ch,
  input  wire queue_status_t q_stat,
  output logic               push,
  output point_t             push_data
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_GOT_FF = 3'd1;
  localparam logic [2:0] PH_AZ_LO  = 3'd2;
  localparam logic [2:0] PH_AZ_HI  = 3'd3;
  localparam logic [2:0] PH_RECORD = 3'd4;
  localparam logic [2:0] PH_SKIP_A = 3'd5;
  localparam logic [2:0] PH_SKIP_B = 3'd6;

  localparam logic [1:0] REC_DIST_LO = 2'd0;
  localparam logic [1:0] REC_DIST_HI = 2'd1;
  localparam logic [1:0] REC_REFL    = 2'd2;

  localparam logic [4:0] LAST_CH  = 5'(CHANNELS_PER_BLOCK - 1);
  localparam logic [3:0] LAST_BLK = 4'(BLOCKS_PER_PACKET - 1);

  logic [2:0]  phase;
  logic [1:0]  byte_in_record;
  logic [4:0]  channel_count;
  logic [3:0]  block_count;
  logic [15:0] azimuth_reg;
  logic [15:0] distance_reg;

  logic accept;
  logic rec_end;
  logic last_ch;
  logic last_blk;

  // Bytes are taken whenever the queue has room
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign last_ch  = channel_count >= LAST_CH;
  assign last_blk = block_count >= LAST_BLK;
  assign rec_end  = (phase == PH_RECORD) && (byte_in_record != REC_DIST_LO)
                    && (byte_in_record != REC_DIST_HI);

  // Point produced on the reflectivity byte
  assign push = accept && rec_end;
  always_comb begin
    push_data.azimuth        = azimuth_reg;
    push_data.channel_id     = {1'b0, channel_count} + 6'd1;
    push_data.distance       = distance_reg;
    push_data.reflectivity   = in_ch.in_byte;
    push_data.block_index    = block_count;
    push_data.last_of_packet = last_ch && last_blk;
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEARCH;
      byte_in_record <= REC_DIST_LO;
      channel_count  <= '0;
      block_count    <= '0;
      azimuth_reg    <= '0;
      distance_reg   <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_SEARCH: begin
          if (in_ch.in_byte == FLAG_FIRST) phase <= PH_GOT_FF;
        end
        PH_GOT_FF: begin
          if (in_ch.in_byte == FLAG_SECOND) begin
            phase       <= PH_AZ_LO;
            block_count <= '0;
          end else if (in_ch.in_byte != FLAG_FIRST) begin
            phase <= PH_SEARCH;
          end
        end
        PH_SKIP_A: phase <= PH_SKIP_B;
        PH_SKIP_B: phase <= PH_AZ_LO;
        PH_AZ_LO: begin
          azimuth_reg <= {8'h00, in_ch.in_byte};
          phase       <= PH_AZ_HI;
        end
        PH_AZ_HI: begin
          azimuth_reg    <= {in_ch.in_byte, azimuth_reg[7:0]};
          byte_in_record <= REC_DIST_LO;
          channel_count  <= '0;
          phase          <= PH_RECORD;
        end
        PH_RECORD: begin
          if (byte_in_record == REC_DIST_LO) begin
            distance_reg   <= {8'h00, in_ch.in_byte};
            byte_in_record <= REC_DIST_HI;
          end else if (byte_in_record == REC_DIST_HI) begin
            distance_reg   <= {in_ch.in_byte, distance_reg[7:0]};
            byte_in_record <= REC_REFL;
          end else begin
            byte_in_record <= REC_DIST_LO;
            if (!last_ch) begin
              channel_count <= channel_count + 5'd1;
            end else if (last_blk) begin
              phase         <= PH_SEARCH;
              block_count   <= '0;
              channel_count <= '0;
            end else begin
              block_count   <= block_count + 4'd1;
              channel_count <= '0;
              phase         <= PH_SKIP_A;
            end
          end
        end
        default: phase <= PH_SEARCH;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lppp_queue.sv
`default_nettype none

// Small point queue between parser and output stage
module lppp_queue
  import lppp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire point_t   push_data,
  input  wire logic     pop,
  output point_t        head,
  output queue_status_t q_stat
);

  point_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;

  // Entry storage, payload only
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lppp_back.sv
`default_nettype none

// Output register: drains the queue into the point channel
module lppp_back
  import lppp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire point_t        head,
  input  wire queue_status_t q_stat,
  output logic               pop,
  lppp_point_if.source       out_ch
);

  logic   out_valid;
  point_t out_data;

  // Load when the register is empty or being taken this cycle
  assign pop = !q_stat.empty && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= head;
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.azimuth        = out_data.azimuth;
  assign out_ch.channel_id     = out_data.channel_id;
  assign out_ch.distance       = out_data.distance;
  assign out_ch.reflectivity   = out_data.reflectivity;
  assign out_ch.block_index    = out_data.block_index;
  assign out_ch.last_of_packet = out_data.last_of_packet;

endmodule

`default_nettype wire

FILE: rtl/lidar_packet_point_parser_unit.sv
// Throughput: one byte per cycle, sustained while the point channel drains.
// Path: the parser writes each point into a four-entry queue when its reflectivity byte is taken,
// and the output register loads it from the queue head when it is empty or being taken.
// The input stalls only when the queue is full; the output register holds under stall.
// Reset (rst, synchronous): parser back to flag search, queue and output emptied.
`default_nettype none

module lidar_packet_point_parser_unit
  import lppp_pkg::*;
#(
  parameter int BLOCKS_PER_PACKET  = 12,
  parameter int CHANNELS_PER_BLOCK = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  lppp_byte_if.sink    in_ch,
  lppp_point_if.source out_ch
);

  logic          push;
  logic          pop;
  point_t        push_data;
  point_t        head;
  queue_status_t q_stat;

  // Front: byte parsing
  lppp_front #(
    .BLOCKS_PER_PACKET (BLOCKS_PER_PACKET),
    .CHANNELS_PER_BLOCK(CHANNELS_PER_BLOCK)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  // Decoupling queue
  lppp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Back: output register
  lppp_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/lppp_checker.sv
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the point channel
module lppp_checker #(
  parameter int BLOCKS_PER_PACKET  = 12,
  parameter int CHANNELS_PER_BLOCK = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] azimuth,
  input wire logic [5:0]  channel_id,
  input wire logic [3:0]  block_index,
  input wire logic        last_of_packet
);

  localparam logic [5:0] LAST_ID  = 6'(CHANNELS_PER_BLOCK);
  localparam logic [3:0] LAST_BLK = 4'(BLOCKS_PER_PACKET - 1);

  logic at_last;

  // Last channel of the last block
  assign at_last = (channel_id == LAST_ID) && (block_index == LAST_BLK);

  // No point may be shown the cycle after reset
  `LPPP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // A stalled point stays offered with its azimuth unchanged
  `LPPP_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(azimuth))

  // Channel numbers run 1 to the channel count
  `LPPP_ASSERT(a_chan_range, clk, rst, out_valid |-> channel_id != 6'd0 && channel_id <= LAST_ID)

  // End of packet marks only the last channel of the last block
  `LPPP_ASSERT(a_last_point, clk, rst, out_valid && last_of_packet |-> at_last)

endmodule

bind lidar_packet_point_parser_unit lppp_checker #(
  .BLOCKS_PER_PACKET (BLOCKS_PER_PACKET),
  .CHANNELS_PER_BLOCK(CHANNELS_PER_BLOCK)
) u_lppp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .azimuth       (out_ch.azimuth),
  .channel_id    (out_ch.channel_id),
  .block_index   (out_ch.block_index),
  .last_of_packet(out_ch.last_of_packet)
);

`default_nettype wire
